### hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge while reset is released
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

### hdl/otl_pkg.sv
// types, widths and the calibration rom of the thermistor linearizer
package otl_pkg;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 14;
  localparam int TEMP_W   = 17;
  localparam int DEG_W    = 9;
  localparam int ROM_SIZE = 61;
  localparam int IDX_W    = 6;
  localparam int OVS_SHIFT = 4;
  // product magnitude |dsum| * |ddeg| * 256 stays below 2^31
  localparam int NUM_W    = 31;
  localparam int DIVC_W   = 5;

  // rom sums in single-sample units, scaled by sixteen on read
  localparam logic [SAMPLE_W-1:0] ROM_ADC [ROM_SIZE] = '{
    10'd23,  10'd25,  10'd27,  10'd28,  10'd31,  10'd33,  10'd35,
    10'd38,  10'd41,  10'd44,  10'd48,  10'd52,  10'd56,  10'd61,
    10'd66,  10'd71,  10'd78,  10'd84,  10'd92,  10'd100, 10'd109,
    10'd120, 10'd131, 10'd143, 10'd156, 10'd171, 10'd187,
    10'd205, 10'd224, 10'd245, 10'd268, 10'd293, 10'd320,
    10'd348, 10'd379, 10'd411, 10'd445, 10'd480, 10'd516,
    10'd553, 10'd591, 10'd628, 10'd665, 10'd702, 10'd737,
    10'd770, 10'd801, 10'd830, 10'd857, 10'd881, 10'd903,
    10'd922, 10'd939, 10'd954, 10'd966, 10'd977, 10'd985,
    10'd993, 10'd999, 10'd1004, 10'd1008
  };

  localparam logic [DEG_W-1:0] ROM_DEG [ROM_SIZE] = '{
    9'd300, 9'd295, 9'd290, 9'd285, 9'd280, 9'd275, 9'd270, 9'd265,
    9'd260, 9'd255, 9'd250, 9'd245, 9'd240, 9'd235, 9'd230, 9'd225,
    9'd220, 9'd215, 9'd210, 9'd205, 9'd200, 9'd195, 9'd190, 9'd185,
    9'd180, 9'd175, 9'd170, 9'd165, 9'd160, 9'd155, 9'd150, 9'd145,
    9'd140, 9'd135, 9'd130, 9'd125, 9'd120, 9'd115, 9'd110, 9'd105,
    9'd100, 9'd95,  9'd90,  9'd85,  9'd80,  9'd75,  9'd70,  9'd65,
    9'd60,  9'd55,  9'd50,  9'd45,  9'd40,  9'd35,  9'd30,  9'd25,
    9'd20,  9'd15,  9'd10,  9'd5,   9'd0
  };

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
  } core_req_t;

  typedef struct packed {
    logic              done;
    logic [TEMP_W-1:0] temp;
  } core_rsp_t;

  function automatic logic [SUM_W-1:0] rom_sum(input logic [IDX_W-1:0] idx);
    rom_sum = {ROM_ADC[idx], {OVS_SHIFT{1'b0}}};
  endfunction

endpackage

### hdl/oversampled_thermistor_linearizer.sv
// oversampled thermistor linearizer: sample accumulator, result register and sequencer
// sequence: a group's last sample starts the rom search, then segment setup, a 31-step
// divide and a finish state; a sum that tops the table goes straight from search to finish
// throughput: one sample per cycle within a group; in_stall is high while the
// sequencer works and on a group's last sample while a result still waits
// reset: synchronous, clears sum, count, sequencer and result valid
module oversampled_thermistor_linearizer #(
  parameter int SAMPLES_PER_RESULT = 16,
  parameter int TABLE_ENTRIES      = 61
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [otl_pkg::SAMPLE_W-1:0] in_adc_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [otl_pkg::SUM_W-1:0]    out_oversampled_sum,
  output logic [otl_pkg::TEMP_W-1:0]   out_temperature_q8
);
  import otl_pkg::*;

  localparam int CNT_W = (SAMPLES_PER_RESULT > 1) ? $clog2(SAMPLES_PER_RESULT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_RESULT - 1);

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r, out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic              in_beat, cnt_last, grp_done;
  core_req_t         req;
  core_rsp_t         rsp;

  assign cnt_last = (cnt_r == CNT_LAST);
  assign in_stall = busy_r | (out_valid_r & cnt_last);
  assign in_beat  = in_valid & ~in_stall;
  assign grp_done = in_beat & cnt_last;
  assign sum_nxt  = sum_r + SUM_W'(in_adc_sample);

  assign req.start = grp_done;
  assign req.sum   = sum_nxt;

  otl_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_beat) begin
        sum_r <= grp_done ? '0 : sum_nxt;
        cnt_r <= grp_done ? '0 : cnt_r + CNT_W'(1);
      end
      if (grp_done) begin
        busy_r <= 1'b1;
      end else if (rsp.done) begin
        busy_r <= 1'b0;
      end
      if (rsp.done) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register is empty whenever a group closes, so the sum loads early
  always_ff @(posedge clk) begin
    if (grp_done) out_sum_r <= sum_nxt;
    if (rsp.done) out_temp_r <= rsp.temp;
  end

  assign out_valid           = out_valid_r;
  assign out_oversampled_sum = out_sum_r;
  assign out_temperature_q8  = out_temp_r;

endmodule

### hdl/otl_sub.sv
// shared subtractor used by the table search, segment setup and divider
module otl_sub (
  input  logic [otl_pkg::SUM_W:0] a,
  input  logic [otl_pkg::SUM_W:0] b,
  output logic [otl_pkg::SUM_W:0] diff,
  output logic                    borrow
);
  import otl_pkg::*;

  logic [SUM_W+1:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[SUM_W:0];
  assign borrow = full[SUM_W+1];

endmodule

### hdl/otl_core.sv
// sequencer: binary table search, segment setup, multiply, serial divide
module otl_core #(
  parameter int TABLE_ENTRIES = 61
) (
  input  logic                clk,
  input  logic                rst_n,
  input  otl_pkg::core_req_t  req,
  output otl_pkg::core_rsp_t  rsp
);
  import otl_pkg::*;

  localparam int N_LIM  = (TABLE_ENTRIES < ROM_SIZE) ? TABLE_ENTRIES : ROM_SIZE;
  localparam int N_USED = (N_LIM < 2) ? 2 : N_LIM;
  localparam logic [IDX_W-1:0] N_IDX = IDX_W'(N_USED);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEARCH = 6'b000010,
    S_DIFF   = 6'b000100,
    S_MUL    = 6'b001000,
    S_DIV    = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [SUM_W-1:0]     raw_r;
  logic [IDX_W-1:0]     lo_r, hi_r;
  logic [SUM_W-1:0]     dmag_r, ds_r, rem_r;
  logic [DEG_W-1:0]     ddeg_r;
  logic                 neg_r;
  logic [NUM_W-1:0]     mag_r;
  logic [DIVC_W-1:0]    cnt_r;

  logic [IDX_W:0]       mid_sum;
  logic [IDX_W-1:0]     mid, seg_lo;
  logic [SUM_W:0]       sub_a, sub_b, sub_diff, neg_diff, rem_sh;
  logic                 sub_borrow;
  logic [SUM_W-1:0]     s0, s1;
  logic [DEG_W-1:0]     v0, v1;
  logic [31:0]          base32, q32;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];
  assign seg_lo  = lo_r - IDX_W'(1);
  assign s0      = rom_sum(seg_lo);
  assign s1      = rom_sum(lo_r);
  assign v0      = ROM_DEG[seg_lo];
  assign v1      = ROM_DEG[lo_r];
  assign rem_sh  = {rem_r, mag_r[NUM_W-1]};
  assign neg_diff = ~sub_diff + (SUM_W+1)'(1);

  always_comb begin
    case (state_r)
      S_SEARCH: begin
        sub_a = {1'b0, raw_r};
        sub_b = {1'b0, rom_sum(mid)};
      end
      S_DIFF: begin
        sub_a = {1'b0, raw_r};
        sub_b = {1'b0, s0};
      end
      S_DIV: begin
        sub_a = rem_sh;
        sub_b = {1'b0, ds_r};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  otl_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (req.start) state_nxt = S_SEARCH;
      S_SEARCH: begin
        if (lo_r == hi_r) state_nxt = (lo_r == N_IDX) ? S_FIN : S_DIFF;
      end
      S_DIFF:   state_nxt = S_MUL;
      S_MUL:    state_nxt = (ds_r == '0) ? S_FIN : S_DIV;
      S_DIV:    if (cnt_r == '0) state_nxt = S_FIN;
      S_FIN:    state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        raw_r <= req.sum;
        lo_r  <= IDX_W'(1);
        hi_r  <= N_IDX;
      end
      S_SEARCH: begin
        if (lo_r == hi_r) begin
          // search done, slope cleared; with no entry above the sum the segment start is the last entry
          mag_r <= '0;
          neg_r <= 1'b0;
        end else if (sub_borrow) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + IDX_W'(1);
        end
      end
      S_DIFF: begin
        dmag_r <= sub_borrow ? neg_diff[SUM_W-1:0] : sub_diff[SUM_W-1:0];
        ds_r   <= s1 - s0;
        ddeg_r <= (v1 < v0) ? (v0 - v1) : (v1 - v0);
        neg_r  <= sub_borrow ^ (v1 < v0);
      end
      S_MUL: begin
        mag_r <= {(NUM_W-8)'(dmag_r) * (NUM_W-8)'(ddeg_r), 8'd0};
        rem_r <= '0;
        cnt_r <= DIVC_W'(NUM_W - 1);
      end
      S_DIV: begin
        // restoring divide, quotient bits shift in behind the numerator
        if (!sub_borrow) begin
          rem_r <= sub_diff[SUM_W-1:0];
        end else begin
          rem_r <= rem_sh[SUM_W-1:0];
        end
        mag_r <= {mag_r[NUM_W-2:0], ~sub_borrow};
        cnt_r <= cnt_r - DIVC_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign base32 = 32'({v0, 8'd0});
  assign q32    = 32'(mag_r);

  always_comb begin
    rsp.done = (state_r == S_FIN);
    if (!neg_r) begin
      rsp.temp = TEMP_W'(base32 + q32);
    end else if (q32 > base32) begin
      rsp.temp = '0;
    end else begin
      rsp.temp = TEMP_W'(base32 - q32);
    end
  end

endmodule

### hdl/otl_checker.sv
// port-level checker for the thermistor linearizer and its bind
`include "assert_macros.svh"

module otl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [otl_pkg::SUM_W-1:0]    out_oversampled_sum,
  input logic [otl_pkg::TEMP_W-1:0]   out_temperature_q8
);
  import otl_pkg::*;

  // no result survives reset
  `ASSERT_ALWAYS(a_rst_clears_out, clk, !rst_n |=> !out_valid)

  // a stalled result beat holds
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_oversampled_sum) && $stable(out_temperature_q8))

  // the hottest point of the first segment bounds the temperature
  `ASSERT_CLK(a_temp_range, clk, rst_n, out_valid |-> out_temperature_q8 <= 17'd91520)

  // a fresh result comes only out of a busy sequencer
  `ASSERT_CLK(a_result_after_busy, clk, rst_n, $rose(out_valid) |-> $past(in_stall))

endmodule

bind oversampled_thermistor_linearizer otl_checker u_otl_checker (.*);

### tb/oversampled_thermistor_linearizer_test.sv
// testbench for the oversampled thermistor linearizer: stimulus, scoreboard and checks
`timescale 1ns / 1ps

class therm_scoreboard;
  localparam int KNEE_COUNT = 61;
  localparam int DEG_TOP    = 300;
  localparam int DEG_STEP   = 5;
  localparam int GROUP_LEN  = 16;

  typedef struct packed {
    logic [otl_pkg::SUM_W-1:0]  sum;
    logic [otl_pkg::TEMP_W-1:0] temp;
  } reading_t;

  // calibration knees in single-sample counts; degrees fall by five per knee from 300
  static int knee_adc [KNEE_COUNT] = '{
    23, 25, 27, 28, 31, 33, 35, 38, 41, 44, 48, 52, 56, 61, 66, 71, 78, 84, 92, 100,
    109, 120, 131, 143, 156, 171, 187, 205, 224, 245, 268, 293, 320, 348, 379, 411,
    445, 480, 516, 553, 591, 628, 665, 702, 737, 770, 801, 830, 857, 881, 903, 922,
    939, 954, 966, 977, 985, 993, 999, 1004, 1008
  };

  logic [otl_pkg::SUM_W-1:0] acc_sum;
  int unsigned               acc_count;
  reading_t                  pending_readings [$];
  int unsigned               mismatches;
  int unsigned               samples_seen;
  int unsigned               readings_checked;
  int unsigned               min_sum;
  int unsigned               max_sum;

  function new();
    acc_sum          = '0;
    acc_count        = 0;
    mismatches       = 0;
    samples_seen     = 0;
    readings_checked = 0;
    min_sum          = 32'hffff_ffff;
    max_sum          = 0;
  endfunction

  function logic [otl_pkg::TEMP_W-1:0] temp_for_sum(logic [otl_pkg::SUM_W-1:0] sum);
    longint seg_lo;
    longint seg_hi;
    longint num;
    longint t;
    for (int i = 1; i < KNEE_COUNT; i++) begin
      if (knee_adc[i] * GROUP_LEN > int'(sum)) begin
        seg_lo = knee_adc[i-1] * GROUP_LEN;
        seg_hi = knee_adc[i] * GROUP_LEN;
        num    = (longint'(sum) - seg_lo) * longint'(-DEG_STEP) * 256;
        t      = longint'(DEG_TOP - DEG_STEP * (i - 1)) * 256;
        // signed division truncates toward zero
        if (seg_hi > seg_lo) t = t + num / (seg_hi - seg_lo);
        if (t < 0) t = 0;
        return t[otl_pkg::TEMP_W-1:0];
      end
    end
    // at or above the last knee: its degrees, which are zero
    return otl_pkg::TEMP_W'(longint'(DEG_TOP - DEG_STEP * (KNEE_COUNT - 1)) * 256);
  endfunction

  function void note_sample(logic [otl_pkg::SAMPLE_W-1:0] adc);
    reading_t r;
    samples_seen++;
    acc_sum = acc_sum + adc;
    acc_count++;
    if (acc_count >= GROUP_LEN) begin
      r.sum  = acc_sum;
      r.temp = temp_for_sum(acc_sum);
      pending_readings.push_back(r);
      if (acc_sum < min_sum) min_sum = acc_sum;
      if (acc_sum > max_sum) max_sum = acc_sum;
      acc_sum   = '0;
      acc_count = 0;
    end
  endfunction

  function void check_result(logic [otl_pkg::SUM_W-1:0] sum,
                             logic [otl_pkg::TEMP_W-1:0] temp);
    reading_t r;
    if (pending_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected reading sum=%0d temp=%0d", sum, temp);
      return;
    end
    r = pending_readings.pop_front();
    readings_checked++;
    if (sum !== r.sum || temp !== r.temp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: reading %0d: sum exp %0d got %0d, temp exp %0d got %0d",
                 readings_checked, r.sum, sum, r.temp, temp);
    end
  endfunction
endclass

module oversampled_thermistor_linearizer_test;
  localparam int GROUP_LEN    = 16;
  localparam int SUM_MAX      = 16368;
  localparam int RAND_GROUPS  = 70;
  localparam int QUIET_GROUPS = 8;
  localparam int SAMPLE_MAX   = (1 << otl_pkg::SAMPLE_W) - 1;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [otl_pkg::SAMPLE_W-1:0] in_adc_sample = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [otl_pkg::SUM_W-1:0]    out_oversampled_sum;
  logic [otl_pkg::TEMP_W-1:0]   out_temperature_q8;

  therm_scoreboard sb = new();
  bit              quiet = 1'b0;
  int unsigned     gap_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     stall_left = 0;
  int unsigned     stall_cycles = 0;

  oversampled_thermistor_linearizer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_adc_sample       (in_adc_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_oversampled_sum (out_oversampled_sum),
    .out_temperature_q8  (out_temperature_q8)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // reader side: stall bursts, with the burst rate changing now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles % 200 == 0) begin
        case ($urandom_range(2, 0))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 30;
        endcase
      end
      if (stall_left == 0 && !quiet && $urandom_range(99, 0) < stall_pct)
        stall_left = $urandom_range(15, 1);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_oversampled_sum, out_temperature_q8);
  end

  task send_sample(input logic [otl_pkg::SAMPLE_W-1:0] adc);
    if (!quiet && gap_pct != 0 && $urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_adc_sample <= adc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(adc);
  endtask

  // splits a target sum over one group; a negative target gives free random samples
  task send_group(input int target);
    int rest;
    int lo;
    int hi;
    int adc;
    rest = target;
    for (int k = 0; k < GROUP_LEN; k++) begin
      if (target < 0) begin
        adc = $urandom_range(SAMPLE_MAX, 0);
      end else begin
        lo = rest - SAMPLE_MAX * (GROUP_LEN - 1 - k);
        if (lo < 0) lo = 0;
        hi = (rest < SAMPLE_MAX) ? rest : SAMPLE_MAX;
        adc = $urandom_range(hi, lo);
        rest = rest - adc;
      end
      send_sample(adc[otl_pkg::SAMPLE_W-1:0]);
    end
  endtask

  function automatic int pick_target();
    int t;
    int sel;
    int edges [12] = '{0, 1, 367, 368, 369, 399, 400, 16127, 16128, 16129, 16367, SUM_MAX};
    sel = $urandom_range(99, 0);
    if (sel < 20) begin
      t = -1;
    end else if (sel < 55) begin
      t = $urandom_range(SUM_MAX, 0);
    end else if (sel < 90) begin
      // land on or right next to a calibration knee
      t = sb.knee_adc[$urandom_range(60, 0)] * GROUP_LEN
          + int'($urandom_range(6, 0)) - 3;
      if (t < 0) t = 0;
      if (t > SUM_MAX) t = SUM_MAX;
    end else begin
      t = edges[$urandom_range(11, 0)];
    end
    return t;
  endfunction

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-scale group lands past the last knee, all-zero group extrapolates the first segment
    send_group(SUM_MAX);
    send_group(0);

    for (int g = 0; g < RAND_GROUPS; g++) begin
      if (g >= RAND_GROUPS - QUIET_GROUPS) quiet = 1'b1;
      case ($urandom_range(2, 0))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 40;
      endcase
      send_group(pick_target());
    end
    in_valid <= 1'b0;

    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d samples, %0d readings checked", sb.samples_seen,
             sb.readings_checked);
    $display("group sums spanned %0d to %0d, %0d mismatches", sb.min_sum, sb.max_sum,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/otl_pkg.sv
hdl/otl_sub.sv
hdl/otl_core.sv
hdl/oversampled_thermistor_linearizer.sv
hdl/otl_checker.sv
tb/oversampled_thermistor_linearizer_test.sv
